/* src/pib_pkg.sv */
// ----------------------------------------------------------------------------
// pib_pkg : shared types and constants of the paged item bitmap
// Operation and status codes, field widths, parameter defaults and the
// memory port control word used by the bitmap sequencer and its parts.
// ----------------------------------------------------------------------------
package pib_pkg;

  // Field widths of the command and result words
  localparam int KIND_W       = 3;
  localparam int PAGE_W       = 16;
  localparam int ITEM_W       = 16;
  localparam int COUNT_W      = 9;
  localparam int STATUS_W     = 3;
  localparam int SET_W        = 17;
  localparam int TOTAL_W      = 17;
  localparam int PAGE_COUNT_W = 11;

  localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RESET = 11'd1024;

  // Parameter defaults
  localparam int DEF_MAX_PAGES = 1024;
  localparam int DEF_MAX_BITS  = 65536;
  localparam int DEF_MAX_ITEMS = 291;

  // Command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 3'd0,
    KIND_SET   = 3'd1,
    KIND_CLEAR = 3'd2,
    KIND_TEST  = 3'd3,
    KIND_COUNT = 3'd4,
    KIND_WIPE  = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_PAGE     = 3'd1,
    ST_ITEM     = 3'd2,
    ST_CAPACITY = 3'd3,
    ST_TOO_MANY = 3'd4
  } status_t;

  // Operations of the shared arithmetic unit
  typedef enum logic {
    ALU_ADD    = 1'b0,
    ALU_POPACC = 1'b1
  } alu_op_t;

  // Control word of a single-port memory
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

/* src/pib_ram.sv */
// ----------------------------------------------------------------------------
// pib_ram : single-port memory with registered read data
// One access per cycle: a write, or a read whose word appears next cycle.
// ----------------------------------------------------------------------------
module pib_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  pib_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]      addr,
  input  logic [W-1:0]       wdata,
  output logic [W-1:0]       rdata
);
  import pib_pkg::*;

  logic [W-1:0] mem [DEPTH];

  // Write the addressed word, or register its contents
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* src/pib_alu.sv */
// ----------------------------------------------------------------------------
// pib_alu : shared adder of the bitmap sequencer
// Adds two operands, or adds the population count of one byte to an
// accumulator. Serves page ends, bit positions, byte totals and counting.
// ----------------------------------------------------------------------------
module pib_alu #(
  parameter int W = 18
) (
  input  pib_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y
);
  import pib_pkg::*;

  logic [3:0] pop;

  // Count the ones of the low byte
  always_comb begin
    pop = 4'd0;
    for (int i = 0; i < 8; i++) begin
      pop = pop + {3'd0, b[i]};
    end
  end

  // Select the second addend
  always_comb begin
    unique case (op)
      ALU_ADD:    y = a + b;
      ALU_POPACC: y = a + W'(pop);
      default:    y = a + b;
    endcase
  end

endmodule

/* src/paged_item_bitmap_unit.sv */
// ----------------------------------------------------------------------------
// paged_item_bitmap_unit : one bit per (page, item) in a flat bit store
// Pages are appended with an item count; each page's items follow those of
// the page before. Set, clear and test one item bit, count all set bits in
// the used bytes, or wipe the store. One command at a time, one result each.
//
//   channel   ports                                      handshake
//   command   kind page item_index item_count            start, busy
//   result    status bit_value set_count total_items     done (one cycle)
//   config    cfg_wr_data (page_count)                   cfg_wr_en
//
// Steps to the result: add passes check, fetch, add; set, clear and test
// check, fetch, position, modify; count walks the used bytes, wipe the whole
// store; a spare code or refused page or item count replies after check.
// The page table and bit store each have one port; count and wipe walk the
// store one byte a cycle. After reset a clearing pass zeroes the store
// with busy high; configuration writes are taken.
// The receiver cannot stall: done is high for exactly one cycle, busy falls after it.
// ----------------------------------------------------------------------------
module paged_item_bitmap_unit #(
  parameter int MAX_PAGES = pib_pkg::DEF_MAX_PAGES,
  parameter int MAX_BITS  = pib_pkg::DEF_MAX_BITS,
  parameter int MAX_ITEMS = pib_pkg::DEF_MAX_ITEMS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pib_pkg::KIND_W-1:0]        kind,
  input  logic [pib_pkg::PAGE_W-1:0]        page,
  input  logic [pib_pkg::ITEM_W-1:0]        item_index,
  input  logic [pib_pkg::COUNT_W-1:0]       item_count,
  input  logic                              cfg_wr_en,
  input  logic [pib_pkg::PAGE_COUNT_W-1:0]  cfg_wr_data,
  output logic                              done,
  output logic [pib_pkg::STATUS_W-1:0]      status,
  output logic                              bit_value,
  output logic [pib_pkg::SET_W-1:0]         set_count,
  output logic [pib_pkg::TOTAL_W-1:0]       total_items
);
  import pib_pkg::*;

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int BYTE_AW     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CNT_W       = BYTE_AW + 1;
  localparam int PAGE_AW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PA_W        = $clog2(MAX_PAGES + 1);
  localparam int TOT_W       = $clog2(MAX_BITS + 1);
  localparam int DW          = ((TOT_W > ITEM_W) ? TOT_W : ITEM_W) + 1;

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_CLEAR      = 10'b0000000010,
    S_CHECK      = 10'b0000000100,
    S_FETCH      = 10'b0000001000,
    S_ADD        = 10'b0000010000,
    S_POS        = 10'b0000100000,
    S_MODIFY     = 10'b0001000000,
    S_COUNT      = 10'b0010000000,
    S_COUNT_LAST = 10'b0100000000,
    S_REPLY      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Registers
  logic [PAGE_COUNT_W-1:0] page_count;
  logic [KIND_W-1:0]       op_kind;
  logic [PAGE_W-1:0]       op_page;
  logic [ITEM_W-1:0]       op_item;
  logic [COUNT_W-1:0]      op_count;
  logic [PA_W-1:0]         pages_added;
  logic [TOT_W-1:0]        item_total;
  logic [TOT_W-1:0]        start_pos;
  logic [TOT_W-1:0]        end_pos;
  logic [DW-1:0]           bit_pos;
  logic [CNT_W-1:0]        byte_idx;
  logic [CNT_W-1:0]        byte_total;
  logic [DW-1:0]           acc;
  logic                    pend;
  logic                    wiping;
  status_t                 res_status;
  logic                    res_bit;

  // Datapath wires
  alu_op_t           alu_op;
  logic [DW-1:0]     alu_a, alu_b, alu_y;
  mem_ctl_t          pt_ctl, bs_ctl;
  logic [PAGE_AW-1:0] pt_addr;
  logic [TOT_W-1:0]  pt_wdata, pt_rdata;
  logic [BYTE_AW-1:0] bs_addr;
  logic [7:0]        bs_wdata, bs_rdata, bit_mask;
  logic [PAGE_W-1:0] page_prev;
  logic              accept, in_limit, page_added, is_bit_op, more, clear_last;
  logic              add_over, item_ok;

  assign accept     = start && !busy;
  assign page_prev  = op_page - PAGE_W'(1);
  assign in_limit   = (32'(op_page) < 32'(page_count)) && (32'(op_page) < 32'(MAX_PAGES));
  assign page_added = 32'(op_page) < 32'(pages_added);
  assign is_bit_op  = (op_kind == KIND_SET) || (op_kind == KIND_CLEAR) ||
                      (op_kind == KIND_TEST);
  assign more       = byte_idx < byte_total;
  assign clear_last = 32'(byte_idx) == 32'(STORE_BYTES - 1);
  assign add_over   = 32'(alu_y) > 32'(MAX_BITS);
  // A valid item always lies below the used byte count, so no byte bound check
  assign item_ok    = bit_pos < DW'(end_pos);
  assign bit_mask   = 8'd1 << bit_pos[2:0];

  pib_alu #(.W(DW)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  pib_ram #(.W(TOT_W), .DEPTH(MAX_PAGES), .AW(PAGE_AW)) u_page_table (
    .clk   (clk),
    .ctl   (pt_ctl),
    .addr  (pt_addr),
    .wdata (pt_wdata),
    .rdata (pt_rdata)
  );

  pib_ram #(.W(8), .DEPTH(STORE_BYTES), .AW(BYTE_AW)) u_bit_store (
    .clk   (clk),
    .ctl   (bs_ctl),
    .addr  (bs_addr),
    .wdata (bs_wdata),
    .rdata (bs_rdata)
  );

  // Route operands to the shared adder
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    if (pend) begin
      alu_op = ALU_POPACC;
      alu_a  = acc;
      alu_b  = DW'(bs_rdata);
    end else if (state == S_CHECK) begin
      alu_a = DW'(item_total);
      alu_b = DW'(7);
    end else if (state == S_ADD) begin
      alu_a = DW'(start_pos);
      alu_b = DW'(op_count);
    end else if (state == S_POS) begin
      alu_a = DW'(start_pos);
      alu_b = DW'(op_item);
    end
  end

  // Sequence the steps and drive the memory ports
  always_comb begin
    state_next = state;
    pt_ctl     = '0;
    pt_addr    = page_prev[PAGE_AW-1:0];
    pt_wdata   = TOT_W'(alu_y);
    bs_ctl     = '0;
    bs_addr    = byte_idx[BYTE_AW-1:0];
    bs_wdata   = 8'd0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CLEAR: begin
        bs_ctl = '{en: 1'b1, we: 1'b1};
        if (clear_last) state_next = wiping ? S_REPLY : S_IDLE;
      end
      S_CHECK: begin
        priority if (op_kind == KIND_ADD) begin
          if (!in_limit || (32'(op_page) > 32'(pages_added)) ||
              (32'(op_count) > 32'(MAX_ITEMS))) begin
            state_next = S_REPLY;
          end else begin
            pt_ctl     = '{en: 1'b1, we: 1'b0};
            state_next = S_FETCH;
          end
        end else if (is_bit_op) begin
          if (!in_limit || !page_added) begin
            state_next = S_REPLY;
          end else begin
            pt_ctl     = '{en: 1'b1, we: 1'b0};
            state_next = S_FETCH;
          end
        end else if (op_kind == KIND_COUNT) begin
          state_next = S_COUNT;
        end else if (op_kind == KIND_WIPE) begin
          state_next = S_CLEAR;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_FETCH: begin
        if (op_kind == KIND_ADD) begin
          state_next = S_ADD;
        end else begin
          pt_ctl     = '{en: 1'b1, we: 1'b0};
          pt_addr    = op_page[PAGE_AW-1:0];
          state_next = S_POS;
        end
      end
      S_ADD: begin
        pt_addr = op_page[PAGE_AW-1:0];
        if (!add_over) pt_ctl = '{en: 1'b1, we: 1'b1};
        state_next = S_REPLY;
      end
      S_POS: begin
        bs_ctl     = '{en: 1'b1, we: 1'b0};
        bs_addr    = alu_y[BYTE_AW+2:3];
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        bs_addr = bit_pos[BYTE_AW+2:3];
        if (item_ok && (op_kind != KIND_TEST)) begin
          bs_ctl   = '{en: 1'b1, we: 1'b1};
          bs_wdata = (op_kind == KIND_SET) ? (bs_rdata | bit_mask) : (bs_rdata & ~bit_mask);
        end
        state_next = S_REPLY;
      end
      S_COUNT: begin
        if (more) begin
          bs_ctl = '{en: 1'b1, we: 1'b0};
        end else begin
          state_next = S_COUNT_LAST;
        end
      end
      S_COUNT_LAST: begin
        state_next = S_REPLY;
      end
      S_REPLY: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state; start with a clearing pass over the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      page_count  <= PAGE_COUNT_RESET;
      pages_added <= '0;
      item_total  <= '0;
      byte_idx    <= '0;
      pend        <= 1'b0;
      wiping      <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_COUNT) && more;
      if (cfg_wr_en) page_count <= cfg_wr_data;
      if (state == S_CLEAR) begin
        byte_idx <= clear_last ? '0 : byte_idx + CNT_W'(1);
      end else if (state == S_COUNT) begin
        if (more) byte_idx <= byte_idx + CNT_W'(1);
        else      byte_idx <= '0;
      end
      if (accept) wiping <= (kind == KIND_WIPE);
      if ((state == S_ADD) && !add_over) begin
        pages_added <= PA_W'(32'(op_page) + 32'd1);
        item_total  <= TOT_W'(alu_y);
      end
    end
  end

  // Capture the command and advance the working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= kind;
      op_page    <= page;
      op_item    <= item_index;
      op_count   <= item_count;
      acc        <= '0;
      res_bit    <= 1'b0;
      res_status <= ST_OK;
    end
    if (pend) acc <= alu_y;
    unique case (state)
      S_CHECK: begin
        byte_total <= alu_y[CNT_W+2:3];
        if (op_kind == KIND_ADD) begin
          if (!in_limit || (32'(op_page) > 32'(pages_added))) begin
            res_status <= ST_PAGE;
          end else if (32'(op_count) > 32'(MAX_ITEMS)) begin
            res_status <= ST_TOO_MANY;
          end
        end else if (is_bit_op && (!in_limit || !page_added)) begin
          res_status <= ST_PAGE;
        end
      end
      S_FETCH: begin
        start_pos <= (op_page == '0) ? '0 : pt_rdata;
      end
      S_ADD: begin
        if (add_over) res_status <= ST_CAPACITY;
      end
      S_POS: begin
        end_pos <= pt_rdata;
        bit_pos <= alu_y;
      end
      S_MODIFY: begin
        if (!item_ok) begin
          res_status <= ST_ITEM;
        end else if (op_kind == KIND_TEST) begin
          res_bit <= |(bs_rdata & bit_mask);
        end
      end
      default: begin
      end
    endcase
  end

  // Present the result; done is high for one cycle
  assign busy        = (state != S_IDLE);
  assign done        = (state == S_REPLY);
  assign status      = res_status;
  assign bit_value   = res_bit;
  assign set_count   = SET_W'(acc);
  assign total_items = TOTAL_W'(item_total);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not start work");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(item_total) <= 32'(MAX_BITS))
    else $error("item total beyond store capacity");
  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pages_added) <= 32'(MAX_PAGES))
    else $error("more pages added than the table holds");
  a_bit_ok: assert property (@(posedge clk) disable iff (rst)
    (done && bit_value) |-> (status == ST_OK))
    else $error("tested bit reported with an error status");
`endif

endmodule
